// ===== design/ulmp_pkg.sv =====
// Shared types and codes for the update-list message parser.
`default_nettype none

package ulmp_pkg;

    // Parser phase codes
    localparam logic [2:0] PH_TYPE   = 3'd0;
    localparam logic [2:0] PH_COUNT  = 3'd1;
    localparam logic [2:0] PH_LEN    = 3'd2;
    localparam logic [2:0] PH_NAME   = 3'd3;
    localparam logic [2:0] PH_SIZE   = 3'd4;
    localparam logic [2:0] PH_DIGEST = 3'd5;
    localparam logic [2:0] PH_DONE   = 3'd6;

    // Field kind codes reported with each byte
    localparam logic [2:0] KIND_TYPE    = 3'd0;
    localparam logic [2:0] KIND_COUNT   = 3'd1;
    localparam logic [2:0] KIND_LENGTH  = 3'd2;
    localparam logic [2:0] KIND_NAME    = 3'd3;
    localparam logic [2:0] KIND_SIZE    = 3'd4;
    localparam logic [2:0] KIND_DIGEST  = 3'd5;
    localparam logic [2:0] KIND_IGNORED = 3'd6;

    // Last byte offsets of the fixed-size fields
    localparam logic [2:0]  SIZE_LAST   = 3'd7;
    localparam logic [15:0] DIGEST_LAST = 16'd15;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       first_byte;
    } req_t;

    typedef struct packed {
        logic [2:0]  field_kind;
        logic [7:0]  data_byte;
        logic [7:0]  entry_number;
        logic [15:0] field_offset;
        logic [15:0] name_length;
        logic [63:0] file_size;
        logic        length_done;
        logic        size_done;
        logic        entry_done;
        logic        message_done;
    } rsp_t;

endpackage

`default_nettype wire

// ===== design/update_list_message_parser.sv =====
// Update-list message parser: byte tagging with input and result registers.
//
// Usage: one message byte per request on the req channel (byte_value,
// first_byte); first_byte restarts parsing with that byte as the type byte.
// Each request yields exactly one result on the rsp channel that tags the
// byte with its field kind, entry number and field offset, and carries the
// assembled name length, file size and entry/message end flags.
// Path: an accepted request waits in the input register, then moves to the
// result register, whose content is presented on the rsp channel.
// Throughput: one request per cycle while rsp_stall is low; parser state
// updates in the same cycle the byte moves from input to result register.
// Stall: while rsp_stall holds the result, the input register fills and
// then req_stall rises; no request or result is lost or repeated.
// Reset: both registers empty, parser waits for a type byte, entry state
// and accumulators cleared.
`default_nettype none

module update_list_message_parser
    import ulmp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    logic  in_valid_reg;
    req_t  in_data_reg;
    logic  out_valid_reg;
    rsp_t  out_data_reg;
    logic  advance;
    logic  take;
    rsp_t  step_rsp;

    // Move the held request into the result register when it is free
    assign advance   = in_valid_reg && (!out_valid_reg || !rsp_stall);
    assign req_stall = in_valid_reg && !advance;
    assign take      = req_valid && !req_stall;

    ulmp_step u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .req   (in_data_reg),
        .rsp   (step_rsp)
    );

    // Track occupancy of input and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (!rsp_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Load payloads
    always_ff @(posedge clk)
    begin
        if (take)
            in_data_reg <= req;
        if (advance)
            out_data_reg <= step_rsp;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

endmodule

`default_nettype wire

// ===== design/ulmp_step.sv =====
// Parser state registers and the per-byte decode and update logic.
`default_nettype none

module ulmp_step
    import ulmp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic step,
    input  wire req_t req,
    output rsp_t      rsp
);

    logic [2:0]  phase_reg,        phase_next;
    logic [7:0]  entries_left_reg, entries_left_next;
    logic [7:0]  entry_index_reg,  entry_index_next;
    logic [15:0] length_accum_reg, length_accum_next;
    logic [15:0] byte_counter_reg, byte_counter_next;
    logic [63:0] size_accum_reg,   size_accum_next;

    logic [2:0]  cur_phase;
    logic [15:0] count_inc;
    logic [15:0] length_full;
    logic [63:0] size_merged;
    logic [7:0]  left_dec;

    // Decode one byte against the current phase
    always_comb
    begin
        cur_phase   = req.first_byte ? PH_TYPE : phase_reg;
        count_inc   = byte_counter_reg + 16'd1;
        length_full = {req.byte_value, length_accum_reg[7:0]};
        size_merged = size_accum_reg
                    | ({56'd0, req.byte_value} << {byte_counter_reg[2:0], 3'b000});
        left_dec    = entries_left_reg - 8'd1;

        phase_next        = phase_reg;
        entries_left_next = entries_left_reg;
        entry_index_next  = entry_index_reg;
        length_accum_next = length_accum_reg;
        byte_counter_next = byte_counter_reg;
        size_accum_next   = size_accum_reg;

        rsp              = '0;
        rsp.field_kind   = KIND_IGNORED;
        rsp.data_byte    = req.byte_value;

        unique case (cur_phase)
            PH_TYPE:
            begin
                rsp.field_kind    = KIND_TYPE;
                entries_left_next = '0;
                entry_index_next  = '0;
                length_accum_next = '0;
                byte_counter_next = '0;
                size_accum_next   = '0;
                phase_next        = PH_COUNT;
            end
            PH_COUNT:
            begin
                rsp.field_kind    = KIND_COUNT;
                entries_left_next = req.byte_value;
                entry_index_next  = '0;
                if (req.byte_value == 8'd0)
                begin
                    rsp.message_done = 1'b1;
                    phase_next       = PH_DONE;
                end
                else
                begin
                    length_accum_next = '0;
                    size_accum_next   = '0;
                    byte_counter_next = '0;
                    phase_next        = PH_LEN;
                end
            end
            PH_LEN:
            begin
                rsp.field_kind   = KIND_LENGTH;
                rsp.entry_number = entry_index_reg;
                rsp.field_offset = byte_counter_reg;
                if (byte_counter_reg == 16'd0)
                begin
                    length_accum_next = {8'd0, req.byte_value};
                    byte_counter_next = 16'd1;
                end
                else
                begin
                    length_accum_next = length_full;
                    rsp.length_done   = 1'b1;
                    rsp.name_length   = length_full;
                    byte_counter_next = '0;
                    phase_next        = (length_full == 16'd0) ? PH_SIZE : PH_NAME;
                end
            end
            PH_NAME:
            begin
                rsp.field_kind   = KIND_NAME;
                rsp.entry_number = entry_index_reg;
                rsp.field_offset = byte_counter_reg;
                byte_counter_next = count_inc;
                if (count_inc == length_accum_reg)
                begin
                    byte_counter_next = '0;
                    phase_next        = PH_SIZE;
                end
            end
            PH_SIZE:
            begin
                rsp.field_kind   = KIND_SIZE;
                rsp.entry_number = entry_index_reg;
                rsp.field_offset = byte_counter_reg;
                size_accum_next   = size_merged;
                byte_counter_next = count_inc;
                if (byte_counter_reg[2:0] == SIZE_LAST)
                begin
                    rsp.size_done     = 1'b1;
                    rsp.file_size     = size_merged;
                    byte_counter_next = '0;
                    phase_next        = PH_DIGEST;
                end
            end
            PH_DIGEST:
            begin
                rsp.field_kind   = KIND_DIGEST;
                rsp.entry_number = entry_index_reg;
                rsp.field_offset = byte_counter_reg;
                byte_counter_next = count_inc;
                if (byte_counter_reg == DIGEST_LAST)
                begin
                    rsp.entry_done    = 1'b1;
                    entries_left_next = left_dec;
                    byte_counter_next = '0;
                    if (left_dec == 8'd0)
                    begin
                        rsp.message_done = 1'b1;
                        phase_next       = PH_DONE;
                    end
                    else
                    begin
                        entry_index_next  = entry_index_reg + 8'd1;
                        length_accum_next = '0;
                        size_accum_next   = '0;
                        phase_next        = PH_LEN;
                    end
                end
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase
    end

    // Advance parser state on each byte that moves to the result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_TYPE;
            entries_left_reg <= '0;
            entry_index_reg  <= '0;
            length_accum_reg <= '0;
            byte_counter_reg <= '0;
            size_accum_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            entries_left_reg <= entries_left_next;
            entry_index_reg  <= entry_index_next;
            length_accum_reg <= length_accum_next;
            byte_counter_reg <= byte_counter_next;
            size_accum_reg   <= size_accum_next;
        end
    end

endmodule

`default_nettype wire
